FILE: rtl/afdd_pkg.sv
// Package for the adaptive frequency drop detector.
// Holds the phase encoding, the calibration constants and the reset margin.
// No dependencies.
`default_nettype none

package afdd_pkg;

  // Phase of the detector, also reported on the mode field.
  typedef enum logic [1:0] {
    PH_CALIB = 2'd0,
    PH_IDLE  = 2'd1,
    PH_EVENT = 2'd2
  } phase_e;

  localparam int unsigned CountW      = 16;
  localparam int unsigned CalibSumW   = 20;
  localparam int unsigned CalibCntW   = 4;
  localparam int unsigned CalibSamples = 5;

  // Divide by CalibSamples as a multiply by a rounded-up reciprocal.
  // With a 24-bit shift the rounding error stays below one for any 20-bit sum.
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipW     = 25;
  localparam int unsigned CalibRecip =
    ((1 << RecipShift) + CalibSamples - 1) / CalibSamples;

  localparam logic [CountW-1:0] MarginReset = 16'd200;
  localparam logic [CountW-1:0] CountMax    = 16'hFFFF;

endpackage

`default_nettype wire

FILE: rtl/afdd_if.sv
// Handshake interfaces for the adaptive frequency drop detector channels.
// Sample input, result output and margin configuration write.
// Depends on afdd_pkg for the field widths.
`default_nettype none

interface afdd_sample_if;
  logic                           valid;
  logic                           ready;
  logic [afdd_pkg::CountW-1:0]    sample_count;

  modport source (output valid, output sample_count, input ready);
  modport sink   (input valid, input sample_count, output ready);
endinterface

interface afdd_result_if;
  logic                           valid;
  logic                           ready;
  logic [afdd_pkg::CountW-1:0]    count_echo;
  logic [1:0]                     mode;
  logic                           event_started;
  logic                           event_ended;
  logic [afdd_pkg::CountW-1:0]    event_ticks;
  logic [afdd_pkg::CountW-1:0]    start_level;
  logic [afdd_pkg::CountW-1:0]    end_level;

  modport source (output valid, output count_echo, output mode, output event_started,
                  output event_ended, output event_ticks, output start_level,
                  output end_level, input ready);
  modport sink   (input valid, input count_echo, input mode, input event_started,
                  input event_ended, input event_ticks, input start_level,
                  input end_level, output ready);
endinterface

interface afdd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [afdd_pkg::CountW-1:0]    margin;

  modport source (output valid, output margin, input ready);
  modport sink   (input valid, input margin, output ready);
endinterface

`default_nettype wire

FILE: rtl/adaptive_frequency_drop_detector.sv
// Adaptive frequency drop detector, top level.
// Uses afdd_pkg and the channel interfaces in afdd_if.sv.
//
// Usage:
//   sample_i carries one pulse count per tick. Each transfer yields exactly
//   one transfer on result_o, in order. cfg_i writes the margin; it is always
//   ready and should be written only while no sample is in flight.
// Pipeline and throughput:
//   A sample is captured in an input register and processed by combinational
//   adds, compares and a multiply-by-reciprocal into the result register.
//   One sample per cycle is sustained while result_o is ready; the state
//   updates in the same cycle that a sample moves to the result register.
// Reset:
//   The detector starts calibrating with zeroed state and a margin of 200;
//   both pipeline stages are empty.
// Stall:
//   While result_o is held off, the result register keeps its contents, the
//   input register fills, and then sample_i.ready drops until the result
//   is taken.
`default_nettype none

module adaptive_frequency_drop_detector (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  afdd_sample_if.sink     sample_i,
  afdd_cfg_if.sink        cfg_i,
  afdd_result_if.source   result_o
);

  localparam int unsigned W = afdd_pkg::CountW;
  localparam int unsigned ProdW = afdd_pkg::CalibSumW + afdd_pkg::RecipW;

  // Pipeline control.
  logic         in_valid_q;
  logic [W-1:0] in_count_q;
  logic         out_valid_q;
  logic         advance;

  // Detector state.
  afdd_pkg::phase_e                  phase_q, phase_d;
  logic [afdd_pkg::CalibSumW-1:0]    calib_sum_q, calib_sum_d;
  logic [afdd_pkg::CalibCntW-1:0]    calib_cnt_q, calib_cnt_d;
  logic [W-1:0]                      baseline_q, baseline_d;
  logic [W-1:0]                      start_thr_q, start_thr_d;
  logic [W-1:0]                      low_min_q, low_min_d;
  logic [W-1:0]                      end_thr_q, end_thr_d;
  logic [W-1:0]                      tick_q, tick_d;
  logic [W-1:0]                      margin_q;

  // Per-sample flags.
  logic         started_d, ended_d;
  logic [W-1:0] ticks_d;

  // Datapath intermediates.
  logic [ProdW-1:0] calib_prod;
  logic [W-1:0]     calib_mean;
  logic [W:0]       fold_sum;
  logic [W-1:0]     base_sel;
  logic [W-1:0]     new_min;
  logic [W:0]       end_sum;

  // Result register payload.
  logic [W-1:0] echo_q;
  logic [1:0]   mode_q;
  logic         started_q, ended_q;
  logic [W-1:0] ticks_q, start_lvl_q, end_lvl_q;

  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !in_valid_q || advance;
  assign cfg_i.ready    = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_count_q <= sample_i.sample_count;
    end
  end

  // Mean of the calibration sum, including the sample being handled.
  assign calib_prod = ProdW'(calib_sum_d) * ProdW'(afdd_pkg::CalibRecip);
  assign calib_mean = calib_prod[afdd_pkg::RecipShift +: W];
  assign fold_sum   = {1'b0, baseline_q} + {1'b0, in_count_q};
  assign new_min    = (in_count_q < low_min_q) ? in_count_q : low_min_q;
  assign end_sum    = {1'b0, new_min} + {1'b0, margin_q};

  // Baseline feeding the start threshold depends on the phase path.
  always_comb begin
    base_sel = fold_sum[W:1];
    if (phase_q == afdd_pkg::PH_CALIB) begin
      base_sel = calib_mean;
    end
  end

  // Next state and result fields for the sample in the input register.
  always_comb begin
    phase_d     = phase_q;
    calib_sum_d = calib_sum_q + afdd_pkg::CalibSumW'(in_count_q);
    calib_cnt_d = calib_cnt_q;
    baseline_d  = baseline_q;
    start_thr_d = start_thr_q;
    low_min_d   = low_min_q;
    end_thr_d   = end_thr_q;
    tick_d      = tick_q;
    started_d   = 1'b0;
    ended_d     = 1'b0;
    ticks_d     = '0;
    case (phase_q)
      afdd_pkg::PH_CALIB: begin
        calib_cnt_d = calib_cnt_q + 1'b1;
        if (calib_cnt_d == afdd_pkg::CalibCntW'(afdd_pkg::CalibSamples)) begin
          baseline_d  = base_sel;
          start_thr_d = (base_sel > margin_q) ? (base_sel - margin_q) : '0;
          phase_d     = afdd_pkg::PH_IDLE;
        end
      end
      afdd_pkg::PH_EVENT: begin
        calib_sum_d = calib_sum_q;
        low_min_d   = new_min;
        end_thr_d   = end_sum[W] ? afdd_pkg::CountMax : end_sum[W-1:0];
        tick_d      = (tick_q != afdd_pkg::CountMax) ? (tick_q + 1'b1) : tick_q;
        if (in_count_q > end_thr_d) begin
          ended_d = 1'b1;
          ticks_d = tick_d;
          phase_d = afdd_pkg::PH_IDLE;
        end
      end
      default: begin
        // Idle, and the unused phase code treated as idle.
        calib_sum_d = calib_sum_q;
        phase_d     = afdd_pkg::PH_IDLE;
        if (in_count_q < start_thr_q) begin
          low_min_d = in_count_q;
          tick_d    = '0;
          phase_d   = afdd_pkg::PH_EVENT;
          started_d = 1'b1;
        end else begin
          baseline_d  = base_sel;
          start_thr_d = (base_sel > margin_q) ? (base_sel - margin_q) : '0;
        end
      end
    endcase
  end

  // State registers, updated as a sample moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= afdd_pkg::PH_CALIB;
      calib_sum_q <= '0;
      calib_cnt_q <= '0;
      baseline_q  <= '0;
      start_thr_q <= '0;
      low_min_q   <= '0;
      end_thr_q   <= '0;
      tick_q      <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      calib_sum_q <= calib_sum_d;
      calib_cnt_q <= calib_cnt_d;
      baseline_q  <= baseline_d;
      start_thr_q <= start_thr_d;
      low_min_q   <= low_min_d;
      end_thr_q   <= end_thr_d;
      tick_q      <= tick_d;
    end
  end

  // Margin register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= afdd_pkg::MarginReset;
    end else if (cfg_i.valid) begin
      margin_q <= cfg_i.margin;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      echo_q      <= in_count_q;
      mode_q      <= phase_d;
      started_q   <= started_d;
      ended_q     <= ended_d;
      ticks_q     <= ticks_d;
      start_lvl_q <= start_thr_d;
      end_lvl_q   <= end_thr_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.count_echo    = echo_q;
  assign result_o.mode          = mode_q;
  assign result_o.event_started = started_q;
  assign result_o.event_ended   = ended_q;
  assign result_o.event_ticks   = ticks_q;
  assign result_o.start_level   = start_lvl_q;
  assign result_o.end_level     = end_lvl_q;

endmodule

`default_nettype wire
